FILE: hw/rtl/sparse_polynomial_evaluator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse polynomial evaluator
// Each macro expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_EVALUATOR_CORE_ASSERT_SVH
`define SPARSE_POLYNOMIAL_EVALUATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared constants and interface types of the sparse polynomial evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int COEF_W      = 16;
	localparam int POINT_W     = 16;
	localparam int FRAC_BITS   = 12;
	localparam int MUL_CHUNK   = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic start;
		logic frac_shift;
	} spe_mul_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} spe_mul_rsp_t;

endpackage

FILE: hw/rtl/spe_front.sv
// ----------------------------------------------------------------------------
// spe_front
// Accepts terms, works out which squarings each term needs, and registers
// the decoded term for the queue.
// ----------------------------------------------------------------------------
module spe_front import spe_pkg::*; #(
	parameter int EXP_BITS = 4,
	parameter int ENTRY_W  = COEF_W + 2 * EXP_BITS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COEF_W-1:0]   coefficient,
	input  logic        [EXP_BITS-1:0] exponent,
	input  logic                       last_term,
	output logic                       item_valid,
	input  logic                       item_ready,
	output logic        [ENTRY_W-1:0]  item_data
);

	logic [EXP_BITS-1:0] sq_mask;
	logic                valid_s1;
	logic [ENTRY_W-1:0]  data_s1;

	// The base is squared after bit i only while a higher exponent bit is set.
	always_comb begin
		for (int i = 0; i < EXP_BITS; i++) begin
			sq_mask[i] = |(exponent >> (i + 1));
		end
	end

	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= {last_term, sq_mask, exponent, coefficient};
		end
	end

	assign item_valid = valid_s1;
	assign item_data  = data_s1;

endmodule

FILE: hw/rtl/spe_queue.sv
// ----------------------------------------------------------------------------
// spe_queue
// Short first-in first-out queue of decoded terms between front and back.
// ----------------------------------------------------------------------------
module spe_queue import spe_pkg::*; #(
	parameter int WIDTH = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/spe_mul.sv
// ----------------------------------------------------------------------------
// spe_mul
// Shared saturating signed multiplier. The magnitude product is built one 16-bit
// slice of the second operand per cycle, then optionally shifted right by the
// fraction width and clamped.
// ----------------------------------------------------------------------------
module spe_mul import spe_pkg::*; #(
	parameter int ACC_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spe_mul_req_t               req,
	input  logic signed [ACC_BITS-1:0] op_a,
	input  logic signed [ACC_BITS-1:0] op_b,
	output spe_mul_rsp_t               rsp,
	output logic signed [ACC_BITS-1:0] result
);

	localparam int W   = ACC_BITS;
	localparam int NCH = (ACC_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BW  = NCH * MUL_CHUNK;
	localparam int PW  = W + BW;
	localparam int CW  = $clog2(NCH);

	typedef enum logic [2:0] {
		MS_IDLE = 3'b001,
		MS_BUSY = 3'b010,
		MS_FIN  = 3'b100
	} mul_state_t;

	mul_state_t             state_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   frac_q;
	logic [W-1:0]           ua_q;
	logic [BW-1:0]          ub_q;
	logic [PW-1:0]          prod_q;
	logic [W-1:0]           result_q;
	logic                   done_q;
	logic                   ovf_q;

	logic [W-1:0]           a_u;
	logic [W-1:0]           b_u;
	logic [W-1:0]           mag_a;
	logic [W-1:0]           mag_b;
	logic [W+MUL_CHUNK-1:0] partial;
	logic [PW-1:0]          shifted;
	logic [PW-1:0]          limit;
	logic                   sat;
	logic [W-1:0]           mag_res;
	logic [W-1:0]           res;

	assign a_u   = op_a;
	assign b_u   = op_b;
	assign mag_a = a_u[W-1] ? (~a_u + W'(1)) : a_u;
	assign mag_b = b_u[W-1] ? (~b_u + W'(1)) : b_u;

	// Most significant slice first, so the running product shifts left each step.
	assign partial = ua_q * ub_q[BW-1 -: MUL_CHUNK];

	assign shifted = frac_q ? (prod_q >> FRAC_BITS) : prod_q;
	assign limit   = PW'({1'b0, {(W-1){1'b1}}}) + PW'(neg_q);
	assign sat     = shifted > limit;
	assign mag_res = sat ? limit[W-1:0] : shifted[W-1:0];
	assign res     = neg_q ? (~mag_res + W'(1)) : mag_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MS_IDLE: begin
					if (req.start) begin
						cnt_q   <= CW'(NCH - 1);
						state_q <= MS_BUSY;
					end
				end
				MS_BUSY: begin
					if (cnt_q == '0) begin
						state_q <= MS_FIN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				MS_FIN: begin
					done_q  <= 1'b1;
					state_q <= MS_IDLE;
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_IDLE && req.start) begin
			neg_q  <= a_u[W-1] ^ b_u[W-1];
			frac_q <= req.frac_shift;
			ua_q   <= mag_a;
			ub_q   <= BW'(mag_b);
			prod_q <= '0;
		end
		if (state_q == MS_BUSY) begin
			prod_q <= (prod_q << MUL_CHUNK) + PW'(partial);
			ub_q   <= ub_q << MUL_CHUNK;
		end
		if (state_q == MS_FIN) begin
			result_q <= res;
			ovf_q    <= sat;
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = done_q && ovf_q;
	assign result   = result_q;

endmodule

FILE: hw/rtl/spe_back.sv
// ----------------------------------------------------------------------------
// spe_back
// Term sequencer: square-and-multiply over the exponent bits on the shared
// multiplier, coefficient scaling, saturating accumulation and the result
// register.
// ----------------------------------------------------------------------------
module spe_back import spe_pkg::*; #(
	parameter int EXP_BITS = 4,
	parameter int ACC_BITS = 48,
	parameter int ENTRY_W  = COEF_W + 2 * EXP_BITS + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  logic        [ENTRY_W-1:0]  q_data,
	input  logic signed [POINT_W-1:0]  eval_point,
	output spe_mul_req_t               mul_req,
	output logic signed [ACC_BITS-1:0] mul_op_a,
	output logic signed [ACC_BITS-1:0] mul_op_b,
	input  spe_mul_rsp_t               mul_rsp,
	input  logic signed [ACC_BITS-1:0] mul_result,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ACC_BITS-1:0] poly_value,
	output logic                       overflowed
);

	localparam int W  = ACC_BITS;
	localparam int IW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
	localparam logic [W-1:0] POWER_ONE = {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0] SUM_MAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SUM_MIN   = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_STEP  = 6'b000010,
		ST_PWAIT = 6'b000100,
		ST_SWAIT = 6'b001000,
		ST_CWAIT = 6'b010000,
		ST_ACC   = 6'b100000
	} back_state_t;

	back_state_t         state_q;
	back_state_t         state_d;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       idx_d;
	logic [COEF_W-1:0]   coef_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [EXP_BITS-1:0] sq_q;
	logic                last_q;
	logic [W-1:0]        power_q;
	logic [W-1:0]        base_q;
	logic [W-1:0]        term_q;
	logic [W-1:0]        sum_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic [W-1:0]        poly_value_q;
	logic                overflowed_q;

	logic                pop;
	logic                advance;
	logic                bit_e;
	logic                bit_s;
	logic                last_bit;
	logic [W-1:0]        power_now;
	logic [W-1:0]        coef_ext;
	logic [W:0]          sum_ext;
	logic                add_ovf;
	logic [W-1:0]        sum_new;
	logic                out_free;
	logic                commit;

	assign q_ready   = state_q == ST_IDLE;
	assign pop       = q_valid && q_ready;
	assign bit_e     = exp_q[idx_q];
	assign bit_s     = sq_q[idx_q];
	assign last_bit  = idx_q == IW'(EXP_BITS - 1);
	assign coef_ext  = {{(W-COEF_W){coef_q[COEF_W-1]}}, coef_q};
	// A power that lands in this very cycle feeds the coefficient multiply directly.
	assign power_now = (state_q == ST_PWAIT) ? mul_result : power_q;

	assign sum_ext  = {sum_q[W-1], sum_q} + {term_q[W-1], term_q};
	assign add_ovf  = sum_ext[W] != sum_ext[W-1];
	assign sum_new  = add_ovf ? (sum_ext[W] ? SUM_MIN : SUM_MAX) : sum_ext[W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == ST_ACC) && (!last_q || out_free);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		mul_req  = '0;
		mul_op_a = power_q;
		mul_op_b = base_q;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					idx_d   = '0;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (bit_e) begin
					mul_req.start      = 1'b1;
					mul_req.frac_shift = 1'b1;
					state_d            = ST_PWAIT;
				end else if (bit_s) begin
					mul_req.start      = 1'b1;
					mul_req.frac_shift = 1'b1;
					mul_op_a           = base_q;
					state_d            = ST_SWAIT;
				end else begin
					advance = 1'b1;
				end
			end
			ST_PWAIT: begin
				if (mul_rsp.done) begin
					if (bit_s) begin
						mul_req.start      = 1'b1;
						mul_req.frac_shift = 1'b1;
						mul_op_a           = base_q;
						state_d            = ST_SWAIT;
					end else begin
						advance = 1'b1;
					end
				end
			end
			ST_SWAIT: begin
				if (mul_rsp.done) begin
					advance = 1'b1;
				end
			end
			ST_CWAIT: begin
				if (mul_rsp.done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (advance) begin
			if (last_bit) begin
				mul_req.start      = 1'b1;
				mul_req.frac_shift = 1'b0;
				mul_op_a           = coef_ext;
				mul_op_b           = power_now;
				state_d            = ST_CWAIT;
			end else begin
				idx_d   = idx_q + IW'(1);
				state_d = ST_STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (commit && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (last_q) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_new;
					ovf_q <= ovf_q | add_ovf;
				end
			end else if (mul_rsp.done) begin
				ovf_q <= ovf_q | mul_rsp.ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			coef_q  <= q_data[COEF_W-1:0];
			exp_q   <= q_data[COEF_W +: EXP_BITS];
			sq_q    <= q_data[COEF_W+EXP_BITS +: EXP_BITS];
			last_q  <= q_data[ENTRY_W-1];
			power_q <= POWER_ONE;
			base_q  <= {{(W-POINT_W){eval_point[POINT_W-1]}}, eval_point};
		end
		if (mul_rsp.done) begin
			if (state_q == ST_PWAIT) begin
				power_q <= mul_result;
			end
			if (state_q == ST_SWAIT) begin
				base_q <= mul_result;
			end
			if (state_q == ST_CWAIT) begin
				term_q <= mul_result;
			end
		end
		if (commit && last_q) begin
			poly_value_q <= sum_new;
			overflowed_q <= ovf_q | add_ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign poly_value = poly_value_q;
	assign overflowed = overflowed_q;

endmodule

FILE: hw/rtl/sparse_polynomial_evaluator_core.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_evaluator_core
// Each term runs its power and squaring multiplies (at most 2*EXP_BITS-1) and then
// its coefficient multiply one after another on the shared multiplier.
// The multiplier sets the rate; a two-entry queue lets terms arrive meanwhile.
// Reset clears the sum, the overflow flag, the point register and all handshakes.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluator_core import spe_pkg::*; #(
	parameter int EXP_BITS = 4,
	parameter int ACC_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic signed [POINT_W-1:0]  eval_point,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COEF_W-1:0]   coefficient,
	input  logic        [EXP_BITS-1:0] exponent,
	input  logic                       last_term,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ACC_BITS-1:0] poly_value,
	output logic                       overflowed
);

	localparam int ENTRY_W = COEF_W + 2 * EXP_BITS + 1;

	logic signed [POINT_W-1:0]  eval_point_q;
	logic                       item_valid;
	logic                       item_ready;
	logic        [ENTRY_W-1:0]  item_data;
	logic                       q_valid;
	logic                       q_ready;
	logic        [ENTRY_W-1:0]  q_data;
	spe_mul_req_t               mul_req;
	spe_mul_rsp_t               mul_rsp;
	logic signed [ACC_BITS-1:0] mul_op_a;
	logic signed [ACC_BITS-1:0] mul_op_b;
	logic signed [ACC_BITS-1:0] mul_result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_point_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			eval_point_q <= eval_point;
		end
	end

	spe_front #(
		.EXP_BITS (EXP_BITS),
		.ENTRY_W  (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coefficient (coefficient),
		.exponent    (exponent),
		.last_term   (last_term),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item_data   (item_data)
	);

	spe_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_ready (item_ready),
		.push_data  (item_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	spe_mul #(
		.ACC_BITS (ACC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.op_a   (mul_op_a),
		.op_b   (mul_op_b),
		.rsp    (mul_rsp),
		.result (mul_result)
	);

	spe_back #(
		.EXP_BITS (EXP_BITS),
		.ACC_BITS (ACC_BITS),
		.ENTRY_W  (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_data     (q_data),
		.eval_point (eval_point_q),
		.mul_req    (mul_req),
		.mul_op_a   (mul_op_a),
		.mul_op_b   (mul_op_b),
		.mul_rsp    (mul_rsp),
		.mul_result (mul_result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.poly_value (poly_value),
		.overflowed (overflowed)
	);

endmodule

FILE: hw/rtl/spe_checker.sv
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks of the sparse polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_evaluator_core_assert.svh"

module spe_checker #(
	parameter int ACC_BITS = 48
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       cfg_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [ACC_BITS-1:0] poly_value,
	input logic                       overflowed
);

	// A stalled result transaction keeps its value and flag.
	`SPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(poly_value) && $stable(overflowed), "result changed while stalled")

	// A presented result is fully defined.
	`SPE_ASSERT_SAME(a_out_known, out_valid, !$isunknown({poly_value, overflowed}), "result holds unknown bits")

	// Handshake outputs are defined out of reset.
	`SPE_ASSERT_SAME(a_ctrl_known, 1'b1, !$isunknown({in_ready, cfg_ready, out_valid}), "handshake output unknown")

endmodule

bind sparse_polynomial_evaluator_core spe_checker #(
	.ACC_BITS (ACC_BITS)
) u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.cfg_ready  (cfg_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.poly_value (poly_value),
	.overflowed (overflowed)
);
